FILE: rtl/core/i2p_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and precedence tables for the infix to postfix converter.
// No dependencies; imported by the converter top level.

package i2p_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	// Character codes with a role in the grammar
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef logic signed [4:0] prec_t;

	localparam prec_t PREC_NONE     = -5'sd1;
	localparam prec_t PREC_ZERO     = 5'sd0;
	localparam prec_t PREC_ADD_IN   = 5'sd1;
	localparam prec_t PREC_ADD_STK  = 5'sd2;
	localparam prec_t PREC_MUL_IN   = 5'sd3;
	localparam prec_t PREC_MUL_STK  = 5'sd4;
	localparam prec_t PREC_POW_STK  = 5'sd5;
	localparam prec_t PREC_POW_IN   = 5'sd6;
	localparam prec_t PREC_OPND_IN  = 5'sd7;
	localparam prec_t PREC_OPND_STK = 5'sd8;
	localparam prec_t PREC_LPAR_IN  = 5'sd9;

	typedef struct packed {
		logic [7:0] symbol;
		logic       expr_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       expr_done;
		logic       overflow;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FLUSH,
		ST_TERM
	} state_t;

	function automatic prec_t prec_in(input logic [7:0] c);
		prec_t p;
		case (c)
			CH_PLUS, CH_MINUS:  p = PREC_ADD_IN;
			CH_STAR, CH_SLASH:  p = PREC_MUL_IN;
			CH_CARET, CH_DOLLAR: p = PREC_POW_IN;
			CH_LPAREN:          p = PREC_LPAR_IN;
			CH_RPAREN:          p = PREC_ZERO;
			default:            p = PREC_OPND_IN;
		endcase
		return p;
	endfunction

	function automatic prec_t prec_stack(input logic [7:0] c);
		prec_t p;
		case (c)
			CH_PLUS, CH_MINUS:  p = PREC_ADD_STK;
			CH_STAR, CH_SLASH:  p = PREC_MUL_STK;
			CH_CARET, CH_DOLLAR: p = PREC_POW_STK;
			CH_LPAREN:          p = PREC_ZERO;
			CH_HASH:            p = PREC_NONE;
			default:            p = PREC_OPND_STK;
		endcase
		return p;
	endfunction

endpackage

FILE: rtl/core/i2p_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM, one write port and one read port, registered read data.
// No dependencies.

module i2p_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// Infix to postfix converter, top level: shunting-yard sequencer around a stack RAM.
// Depends on i2p_pkg and i2p_ram.

// One infix character is taken per item transfer; the postfix characters it
// releases leave as result transfers, the last of them flagged run_last. An
// item with expr_last set also flushes the symbols left on the stack and then
// the NUL terminator (expr_done): the terminator is first queued, then handed
// out, after which the stack is empty again. The stack RAM allows one pop per
// cycle while the result side is not stalled, the symbol below the top being
// read while the current top is handed out. A push onto a full stack
// (STACK_DEPTH-2 symbols) is dropped and raises the overflow bit, which stays
// set until reset. No clearing pass is needed after reset: the sentinel slot
// is implicit and only slots that were pushed are ever read back.

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  i2p_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output i2p_pkg::result_t  result
);

	import i2p_pkg::*;

	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam logic [SP_W-1:0] SP_MAX = SP_W'(STACK_DEPTH - 2);
	localparam logic [SP_W-1:0] SP_ONE = SP_W'(1);

	state_t          state_q, state_d;
	logic [SP_W-1:0] sp_q, sp_d;       // index of top slot, 0 = sentinel
	logic [7:0]      top_q, top_d;     // top symbol after a push
	logic            fresh_q, fresh_d; // top comes from RAM read data
	logic            ovf_q, ovf_d;
	logic [7:0]      sym_q;
	logic            last_q;

	// one-deep holding stage: an emitted char waits here until we know
	// whether another follows it in the same run
	logic            pend_vq, pend_vd;
	logic [7:0]      pend_char_q, pend_char_d;
	logic            pend_done_q, pend_done_d;

	logic            res_vq, res_vd;
	result_t         res_q, res_d;

	logic            ram_we, ram_re;
	logic [SP_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]      ram_wdata, ram_rdata;

	logic [7:0]      top_cur;
	prec_t           pin, pst;
	logic            ofree;
	logic            send, send_last;

	i2p_ram #(
		.WIDTH (8),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign top_cur = (sp_q == '0) ? CH_HASH : (fresh_q ? ram_rdata : top_q);
	assign pin     = prec_in(sym_q);
	assign pst     = prec_stack(top_cur);
	assign ofree   = !res_vq || !result_stall;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = res_vq;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q    <= '0;
			fresh_q <= 1'b0;
			ovf_q   <= 1'b0;
			pend_vq <= 1'b0;
			res_vq  <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			fresh_q <= fresh_d;
			ovf_q   <= ovf_d;
			pend_vq <= pend_vd;
			res_vq  <= res_vd;
		end
	end

	always_ff @(posedge clk) begin
		top_q       <= top_d;
		pend_char_q <= pend_char_d;
		pend_done_q <= pend_done_d;
		res_q       <= res_d;
		if (item_valid && !item_stall) begin
			sym_q  <= item.symbol;
			last_q <= item.expr_last;
		end
	end

	always_comb begin
		state_d     = state_q;
		sp_d        = sp_q;
		top_d       = top_q;
		fresh_d     = fresh_q;
		ovf_d       = ovf_q;
		pend_vd     = pend_vq;
		pend_char_d = pend_char_q;
		pend_done_d = pend_done_q;
		ram_we      = 1'b0;
		ram_waddr   = sp_q + SP_ONE;
		ram_wdata   = sym_q;
		ram_re      = 1'b0;
		ram_raddr   = sp_q - SP_ONE;
		send        = 1'b0;
		send_last   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sp_q != '0 && pst > pin) begin
					// pop and emit the top; fetch the slot below
					if (!pend_vq || ofree) begin
						send        = pend_vq;
						pend_vd     = 1'b1;
						pend_char_d = top_cur;
						pend_done_d = 1'b0;
						sp_d        = sp_q - SP_ONE;
						ram_re      = (sp_q > SP_ONE);
						fresh_d     = 1'b1;
					end
				end else if (!(pend_vq && !last_q) || ofree) begin
					if (pst == pin) begin
						// ')' meets '(': drop both
						sp_d    = sp_q - SP_ONE;
						ram_re  = (sp_q > SP_ONE);
						fresh_d = 1'b1;
					end else if (sp_q >= SP_MAX) begin
						ovf_d = 1'b1;
					end else begin
						ram_we  = 1'b1;
						top_d   = sym_q;
						fresh_d = 1'b0;
						sp_d    = sp_q + SP_ONE;
					end
					if (last_q) begin
						state_d = ST_FLUSH;
					end else begin
						send      = pend_vq;
						send_last = 1'b1;
						pend_vd   = 1'b0;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_vq || ofree) begin
					send        = pend_vq;
					pend_vd     = 1'b1;
					if (sp_q != '0 && top_cur != CH_HASH) begin
						pend_char_d = top_cur;
						pend_done_d = 1'b0;
						sp_d        = sp_q - SP_ONE;
						ram_re      = (sp_q > SP_ONE);
						fresh_d     = 1'b1;
					end else begin
						// stacked '#' or sentinel: drop the rest, queue terminator
						pend_char_d = CH_NUL;
						pend_done_d = 1'b1;
						sp_d        = '0;
						state_d     = ST_TERM;
					end
				end
			end
			ST_TERM: begin
				if (ofree) begin
					send      = 1'b1;
					send_last = 1'b1;
					pend_vd   = 1'b0;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		res_vd = res_vq && result_stall;
		res_d  = res_q;
		if (send) begin
			res_vd          = 1'b1;
			res_d.out_char  = pend_char_q;
			res_d.run_last  = send_last;
			res_d.expr_done = pend_done_q;
			res_d.overflow  = ovf_d;
		end
	end

	// stack never grows past its usable depth
	assert property (@(posedge clk) disable iff (!arst_n) sp_q <= SP_MAX)
		else $error("stack pointer beyond usable depth");

	// nothing left in the holding stage when a new item can be taken
	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_IDLE |-> !pend_vq)
		else $error("pending char left over at item boundary");

	// pushes and pops never touch the RAM in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n) !(ram_we && ram_re))
		else $error("stack RAM read and write in one cycle");

	// terminator always closes the run
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.expr_done |-> result.run_last)
		else $error("terminator without run_last");

	// stack is empty once an expression is closed
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TERM |=> sp_q == '0)
		else $error("stack not reset after terminator");

endmodule

FILE: tb/sv/tb_infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// Self-checking testbench for infix_to_postfix_converter: directed, random, back-pressure
// and stack-full tests against an in-bench shunting-yard model. Depends on i2p_pkg and the RTL.

module tb_infix_to_postfix_converter;
	import i2p_pkg::*;

	localparam int DEPTH        = STACK_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 70;
	localparam int HOLD_CYCLES  = 160;   // long receiver hold-off in the back-pressure test
	localparam int IDLE_PCT     = 19;    // chance per cycle that a side idles
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 60;

	localparam logic [7:0] LETTER_A = 8'h61;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// Shadow of the converter state
	logic [7:0] shadow_stack [DEPTH];
	int         shadow_top;
	bit         shadow_overflow;

	// Postfix characters still owed by the block, oldest first
	result_t postfix_expected [$];

	int mismatches  = 0;
	int items_sent  = 0;
	bit idle_on     = 1'b1;
	int hold_reqs   = 0;
	int hold_served = 0;

	infix_to_postfix_converter #(
		.STACK_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Precedence of a character as it arrives
	function automatic int in_rank(input logic [7:0] c);
		case (c)
			CH_PLUS, CH_MINUS:   return 1;
			CH_STAR, CH_SLASH:   return 3;
			CH_CARET, CH_DOLLAR: return 6;
			CH_LPAREN:           return 9;
			CH_RPAREN:           return 0;
			default:             return 7;
		endcase
	endfunction

	// Precedence of a character once it sits on the stack; a stacked hash never pops
	function automatic int stack_rank(input logic [7:0] c);
		case (c)
			CH_PLUS, CH_MINUS:   return 2;
			CH_STAR, CH_SLASH:   return 4;
			CH_CARET, CH_DOLLAR: return 5;
			CH_LPAREN:           return 0;
			CH_HASH:             return -1;
			default:             return 8;
		endcase
	endfunction

	// Runs one transfer through the shadow stack and queues the characters it releases.
	function automatic void postfix_predict(input item_t pkt);
		logic [7:0] chars [$];
		bit         term_added;
		int         pin;
		result_t    r;
		term_added = 1'b0;
		pin = in_rank(pkt.symbol);
		// pop while the top binds tighter than the incoming character
		while (shadow_top > 0 && stack_rank(shadow_stack[shadow_top]) > pin) begin
			if (chars.size() < DEPTH)
				chars.push_back(shadow_stack[shadow_top]);
			shadow_top--;
		end
		if (stack_rank(shadow_stack[shadow_top]) == pin) begin
			// closing paren meets its opening one: both vanish
			if (shadow_top > 0)
				shadow_top--;
		end else if (shadow_top + 2 >= DEPTH) begin
			shadow_overflow = 1'b1;
		end else begin
			shadow_top++;
			shadow_stack[shadow_top] = pkt.symbol;
		end
		if (pkt.expr_last) begin
			// flush stops at the first hash; anything under it is dropped silently
			while (shadow_top > 0 && shadow_stack[shadow_top] != CH_HASH) begin
				if (chars.size() < DEPTH)
					chars.push_back(shadow_stack[shadow_top]);
				shadow_top--;
			end
			if (chars.size() < DEPTH) begin
				chars.push_back(CH_NUL);
				term_added = 1'b1;
			end
			shadow_top = 0;
		end
		foreach (chars[k]) begin
			r.out_char  = chars[k];
			r.run_last  = (k == chars.size() - 1);
			r.expr_done = term_added && (k == chars.size() - 1);
			r.overflow  = shadow_overflow;
			postfix_expected.push_back(r);
		end
	endfunction

	function automatic bit is_grammar(input logic [7:0] c);
		case (c)
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_DOLLAR,
			CH_LPAREN, CH_RPAREN, CH_HASH: return 1'b1;
			default:                       return 1'b0;
		endcase
	endfunction

	// Mostly lowercase letters, otherwise any code outside the grammar
	function automatic logic [7:0] pick_operand();
		logic [7:0] c;
		if ($urandom_range(99) < 70)
			return LETTER_A + 8'($urandom_range(25));
		do
			c = 8'($urandom_range(255));
		while (is_grammar(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(5))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			3:       return CH_SLASH;
			4:       return CH_CARET;
			default: return CH_DOLLAR;
		endcase
	endfunction

	// One input transfer: optional idle gap, then valid held until accepted.
	task automatic send_symbol(input logic [7:0] sym, input logic last);
		item_t pkt;
		pkt.symbol    = sym;
		pkt.expr_last = last;
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= pkt;
		do
			@(posedge clk);
		while (item_stall);
		postfix_predict(pkt);
		items_sent++;
	endtask

	// Drop valid so a pausing sender does not repeat its last character
	task automatic sender_rest();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_symbol(s[i], i == s.len() - 1);
	endtask

	// Random infix expression, optionally broken or replaced by noise
	task automatic send_expression(input int max_terms, input bit broken);
		logic [7:0] seq [$];
		int         depth;
		int         terms;
		depth = 0;
		terms = $urandom_range(1, max_terms);
		for (int t = 0; t < terms; t++) begin
			while (depth < 6 && $urandom_range(99) < 25) begin
				seq.push_back(CH_LPAREN);
				depth++;
			end
			seq.push_back(pick_operand());
			while (depth > 0 && $urandom_range(99) < 30) begin
				seq.push_back(CH_RPAREN);
				depth--;
			end
			if (t != terms - 1)
				seq.push_back(pick_operator());
		end
		while (depth > 0) begin
			seq.push_back(CH_RPAREN);
			depth--;
		end
		if (broken) begin
			case ($urandom_range(2))
				0: begin
					seq[$urandom_range(seq.size() - 1)] = 8'($urandom_range(255));
				end
				1: begin
					if (seq.size() > 1)
						seq.delete($urandom_range(seq.size() - 1));
				end
				default: begin
					seq.delete();
					repeat ($urandom_range(1, 10))
						seq.push_back(8'($urandom_range(255)));
				end
			endcase
		end
		foreach (seq[i])
			send_symbol(seq[i], i == seq.size() - 1);
	endtask

	// Every operator, parens, right-associative power, a lone close paren,
	// a stacked hash, a NUL operand and the top code
	task automatic test_directed();
		send_text("a+b*c");
		send_text("(a-b)/c");
		send_text("p^q$r");
		send_text(")");
		send_text("a+#b");
		send_symbol(CH_NUL, 1'b0);
		send_symbol(8'hFF, 1'b1);
		sender_rest();
	endtask

	// Mostly well-formed expressions; the middle third runs with no idling
	task automatic test_random();
		int start;
		int done_items;
		start = items_sent;
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			idle_on = !(done_items > RANDOM_ITEMS / 3 && done_items < 2 * RANDOM_ITEMS / 3);
			send_expression(6, $urandom_range(99) < 20);
			done_items = items_sent - start;
		end
		idle_on = 1'b1;
		sender_rest();
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		hold_reqs++;
		repeat (6)
			send_expression(4, 1'b0);
		sender_rest();
	endtask

	// Fill the stack: one expression giving the most results, then one that
	// overflows; the sticky flag must show on everything after it
	task automatic test_stack_full();
		repeat (DEPTH - 3)
			send_symbol(CH_LPAREN, 1'b0);
		send_symbol(LETTER_A, 1'b0);
		send_symbol(CH_PLUS, 1'b1);
		repeat (DEPTH - 1)
			send_symbol(CH_LPAREN, 1'b0);
		send_symbol(CH_RPAREN, 1'b1);
		repeat (4)
			send_expression(5, 1'b0);
		sender_rest();
	endtask

	// Receiver: random stalls, or a long counted hold-off when requested
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_served) begin
				hold_served++;
				result_stall <= 1'b1;
				for (int i = 1; i < HOLD_CYCLES; i++)
					@(negedge clk);
			end else begin
				result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Compare each result transfer with the oldest expected character
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (postfix_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: char %h run_last %b done %b ovf %b",
						result.out_char, result.run_last, result.expr_done, result.overflow);
			end else begin
				want = postfix_expected.pop_front();
				if (result.out_char !== want.out_char || result.run_last !== want.run_last ||
					result.expr_done !== want.expr_done || result.overflow !== want.overflow) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: exp char %h last %b done %b ovf %b, got %h %b %b %b",
							want.out_char, want.run_last, want.expr_done, want.overflow,
							result.out_char, result.run_last, result.expr_done, result.overflow);
				end
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		item_valid      = 1'b0;
		item            = '0;
		shadow_stack[0] = CH_HASH;
		shadow_top      = 0;
		shadow_overflow = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random();
		test_backpressure();
		test_stack_full();

		// drain, then give the block time to show any stray transfer
		while (postfix_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && postfix_expected.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
